@@ hw/rtl/pol_pkg.sv @@
// shared types and constants for the positional ordered list
`default_nettype none
package pol_pkg;
    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_APPEND     = 3'd0,
        CMD_INS_HEAD   = 3'd1,
        CMD_INS_BTAIL  = 3'd2,
        CMD_INS_POS    = 3'd3,
        CMD_DEL_HEAD   = 3'd4,
        CMD_DEL_TAIL   = 3'd5,
        CMD_DEL_POS    = 3'd6,
        CMD_READ       = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SHIFT = 2'd1,
        S_FIN   = 2'd2
    } t_state;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [31:0]   wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } t_ram_req;
endpackage
`default_nettype wire

@@ hw/rtl/pol_ram.sv @@
// entry store: one write port, one registered read port
`default_nettype none
module pol_ram #(
    parameter int N  = 64,
    parameter int AW = 6,
    parameter int DW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [N];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/pol_ctrl.sv @@
// command sequencer: decodes a beat, moves entries one per cycle, builds the result
`default_nettype none
module pol_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [2:0]        i_command,
    input  wire logic [31:0]       i_value,
    input  wire logic [6:0]        i_position,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [1:0]             o_status,
    output logic [6:0]             o_count,
    output logic [31:0]            o_read_value,
    output pol_pkg::t_ram_req      o_ram,
    input  wire logic [31:0]       i_rdata
);
    import pol_pkg::*;

    t_state        r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic          r_ins, n_ins;
    logic          r_rd, n_rd;
    logic          r_pend, n_pend;
    logic [LW-1:0] r_left, n_left;
    logic [AW-1:0] r_ra, n_ra;
    logic [AW-1:0] r_idx, n_idx;
    logic [31:0]   r_val;
    logic [1:0]    r_status, n_status;
    logic          r_ovalid;
    logic [1:0]    r_ostatus;
    logic [6:0]    r_ocount;
    logic [31:0]   r_ordata;

    logic          acc;
    logic          pos_ok;
    logic          out_free;
    logic [LW-1:0] pos_m1;
    t_cmd          cmd;

    assign cmd      = t_cmd'(i_command);
    assign acc      = i_valid && o_ready;
    assign pos_ok   = (int'(i_position) >= 1) && (int'(i_position) <= int'(r_len));
    assign pos_m1   = LW'(int'(i_position) - 1);
    assign out_free = !r_ovalid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (acc) n_state = (n_ins || n_status == ST_OK && !n_rd &&
                                         cmd != CMD_READ && cmd >= CMD_DEL_HEAD)
                                        ? S_SHIFT : S_FIN;
            S_SHIFT: if (!r_pend) n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // decode, ram control and shift bookkeeping
    always_comb begin
        n_len    = r_len;
        n_ins    = r_ins;
        n_rd     = r_rd;
        n_pend   = r_pend;
        n_left   = r_left;
        n_ra     = r_ra;
        n_idx    = r_idx;
        n_status = r_status;
        o_ram    = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_status = ST_OK;
                    n_ins    = 1'b0;
                    n_rd     = 1'b0;
                    n_pend   = 1'b0;
                    n_left   = '0;
                    n_idx    = '0;
                    if (cmd <= CMD_INS_POS) begin
                        if (int'(r_len) >= DEPTH) begin
                            n_status = ST_FULL;
                        end else begin
                            if (r_len == '0 || cmd == CMD_INS_HEAD) begin
                                n_ins = 1'b1;
                                n_idx = '0;
                            end else if (cmd == CMD_APPEND) begin
                                n_ins = 1'b1;
                                n_idx = AW'(r_len);
                            end else if (cmd == CMD_INS_BTAIL) begin
                                n_ins = 1'b1;
                                n_idx = AW'(r_len - 1'b1);
                            end else if (!pos_ok) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_ins = 1'b1;
                                n_idx = AW'(pos_m1);
                            end
                            if (n_ins) begin
                                n_len = r_len + 1'b1;
                                if (r_len != LW'(n_idx)) begin
                                    o_ram.re    = 1'b1;
                                    o_ram.raddr = AW'(r_len - 1'b1);
                                    n_ra        = AW'(r_len - 1'b1);
                                    n_pend      = 1'b1;
                                    n_left      = r_len - LW'(n_idx) - 1'b1;
                                end
                            end
                        end
                    end else begin
                        if (r_len == '0) begin
                            n_status = ST_EMPTY;
                        end else if (cmd == CMD_DEL_HEAD) begin
                            n_idx = '0;
                        end else if (cmd == CMD_DEL_TAIL) begin
                            n_idx = AW'(r_len - 1'b1);
                        end else if (!pos_ok) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_idx = AW'(pos_m1);
                            if (cmd == CMD_READ) begin
                                n_rd        = 1'b1;
                                o_ram.re    = 1'b1;
                                o_ram.raddr = AW'(pos_m1);
                            end
                        end
                        if (n_status == ST_OK && !n_rd) begin
                            n_len = r_len - 1'b1;
                            // entries behind the gap move down
                            if (LW'(n_idx) + 1'b1 < r_len) begin
                                o_ram.re    = 1'b1;
                                o_ram.raddr = n_idx + 1'b1;
                                n_ra        = n_idx + 1'b1;
                                n_pend      = 1'b1;
                                n_left      = r_len - LW'(n_idx) - LW'(2);
                            end
                        end
                    end
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_ins ? r_ra + 1'b1 : r_ra - 1'b1;
                    o_ram.wdata = i_rdata;
                    if (r_left != '0) begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = r_ins ? r_ra - 1'b1 : r_ra + 1'b1;
                        n_ra        = o_ram.raddr;
                        n_left      = r_left - 1'b1;
                    end else begin
                        n_pend = 1'b0;
                    end
                end else if (r_ins) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_idx;
                    o_ram.wdata = r_val;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_pend  <= n_pend;
            if (r_state == S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins    <= n_ins;
        r_rd     <= n_rd;
        r_left   <= n_left;
        r_ra     <= n_ra;
        r_idx    <= n_idx;
        r_status <= n_status;
        if (acc) begin
            r_val <= i_value;
        end
        if (r_state == S_FIN && out_free) begin
            r_ostatus <= r_status;
            r_ocount  <= 7'(r_len);
            r_ordata  <= r_rd ? i_rdata : 32'd0;
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_status     = r_ostatus;
    assign o_count      = r_ocount;
    assign o_read_value = r_ordata;
endmodule
`default_nettype wire

@@ hw/rtl/positional_ordered_list_unit.sv @@
// Positional ordered list: an ordered store of up to DEPTH signed 32-bit entries.
// Input channel (s_axis): one command beat; tdata = command[2:0], value[34:3],
// position[41:35], zero padded to 48 bits. Output channel (m_axis): one result
// beat per command; tdata = status[1:0], count[8:2], read_value[40:9], padded.
// Entries sit in one single-port-write, registered-read memory. Inserts and
// deletes move every entry behind the affected position one place, one entry
// per cycle through a read/write-back pipeline.
// Reads and errors go from idle straight to the finish state, which loads the result
// register; inserts and deletes pass through the shift state, which moves any entries
// and then writes an inserted value. One command is in flight at a time and the next
// beat is taken once the sequencer is back in idle after its result is loaded, so the
// shift loop over the memory sets the rate.
// Reset empties the list (count zero); memory contents are not cleared.
// A stalled receiver holds the result in the output register; the next command
// is still accepted and finishes up to the point of loading its result.
`default_nettype none
module positional_ordered_list_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // command, value, position
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata    // status, count, read_value
);
    import pol_pkg::*;

    t_ram_req    ram_req;
    logic [31:0] rdata;
    logic [1:0]  status;
    logic [6:0]  count;
    logic [31:0] rval;

    pol_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_command    (s_axis_tdata[2:0]),
        .i_value      (s_axis_tdata[34:3]),
        .i_position   (s_axis_tdata[41:35]),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_status     (status),
        .o_count      (count),
        .o_read_value (rval),
        .o_ram        (ram_req),
        .i_rdata      (rdata)
    );

    pol_ram #(.N(DEPTH), .AW(AW), .DW(32)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    assign m_axis_tdata = {7'd0, rval, count, status};
endmodule
`default_nettype wire
